// ===== sv/lbpc_pkg.sv =====
// Shared constants, types and helpers for the LED blink pattern compiler.
package lbpc_pkg;

   localparam int ON_W       = 22;
   localparam int UPT_W      = 20;
   localparam int NW_W       = 4;
   localparam int DELAY_W    = 7;
   localparam int BRIGHT_W   = 8;
   localparam int WUS_W      = 27;   // micros_per_tick * 127
   localparam int REM_W      = 32;   // on_ms * 1000
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int MAX_WORDS_DEF = 8;

   localparam logic [UPT_W-1:0]   UPT_RESET   = UPT_W'(10000);
   localparam logic [NW_W-1:0]    NW_RESET    = NW_W'(8);
   localparam logic [ON_W-1:0]    DEFAULT_MS  = ON_W'(500);
   localparam logic [UPT_W-1:0]   US_PER_MS   = UPT_W'(1000);
   localparam logic [DELAY_W-1:0] BRIGHT_ON   = 7'h7F;
   localparam logic [DELAY_W-1:0] BRIGHT_OFF  = 7'h00;

   typedef enum logic {
      REG_UPT       = 1'b0,
      REG_NUM_WORDS = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // x * 1000 = x * 1024 - x * 16 - x * 8
   function automatic logic [REM_W-1:0] mul1000(input logic [ON_W-1:0] x);
      logic [REM_W-1:0] a;
      logic [REM_W-1:0] b;
      logic [REM_W-1:0] c;
      a = {x, 10'b0};
      b = {6'b0, x, 4'b0};
      c = {7'b0, x, 3'b0};
      return a - b - c;
   endfunction

endpackage

// ===== sv/lbpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lbpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lbpc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module lbpc_div
   import lbpc_pkg::*;
#(
   parameter int DVD_W = WUS_W,
   parameter int DVS_W = UPT_W,
   localparam int CNT_W = $clog2(DVD_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output div_stat_type     stat,
   output logic [DVD_W-1:0] quotient
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] shf_ff, shf_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVS_W:0]   rem_sh;
   logic [DVS_W+1:0] diff;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff, shf_ff[DVD_W-1]};
      diff   = {1'b0, rem_sh} - {2'b0, dvs_ff};
      ge     = !diff[DVS_W+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      shf_in  = shf_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         shf_in = {shf_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         shf_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      shf_ff <= shf_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = shf_ff;

endmodule

// ===== sv/led_blink_pattern_compiler_core.sv =====
// LED blink pattern compiler: turns on/off times into blink control words.
// Work per request: a limit sum by repeated add, then for each control
//   word a select, a take and a 27-step bit-serial divide, then two
//   divisions by 1000 for the realized times, then the read-out of the
//   stored words. A rejected request gives a single error word. One
//   request at a time; the next is accepted once the final word sits in
//   the output register. Synchronous reset clears control state and sets
//   micros_per_tick to 10000 and num_words to 8.
module led_blink_pattern_compiler_core
   import lbpc_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ON_W-1:0]     req_on_ms,
   input  logic [ON_W-1:0]     req_off_ms,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DELAY_W-1:0]  rsp_tick_delay,
   output logic [BRIGHT_W-1:0] rsp_word_brightness,
   output logic                rsp_last,
   output logic                rsp_error,
   output logic [ON_W-1:0]     rsp_actual_on_ms,
   output logic [ON_W-1:0]     rsp_actual_off_ms,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam int WCNT_W = $clog2(MAX_WORDS + 1);
   localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int TOT_W  = WUS_W + WCNT_W;
   localparam int BUF_W  = 1 + DELAY_W;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_TOTAL  = 14'b00000000000010,
      ST_LIMIT  = 14'b00000000000100,
      ST_MUL    = 14'b00000000001000,
      ST_SEL    = 14'b00000000010000,
      ST_TAKE   = 14'b00000000100000,
      ST_WDIV   = 14'b00000001000000,
      ST_CHECK  = 14'b00000010000000,
      ST_FON    = 14'b00000100000000,
      ST_FOFFST = 14'b00001000000000,
      ST_FOFF   = 14'b00010000000000,
      ST_ERD    = 14'b00100000000000,
      ST_EWR    = 14'b01000000000000,
      ST_ERR    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [UPT_W-1:0] upt_ff, upt_in;
   logic [NW_W-1:0]  nw_ff, nw_in;

   // request working set
   logic [ON_W-1:0]   on_ms_ff, on_ms_in;
   logic [ON_W-1:0]   off_ms_ff, off_ms_in;
   logic [WUS_W-1:0]  word_us_ff, word_us_in;
   logic [TOT_W-1:0]  tot_ff, tot_in;
   logic [WCNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]  on_rem_ff, on_rem_in;
   logic [REM_W-1:0]  off_rem_ff, off_rem_in;
   logic              sel_on_ff, sel_on_in;
   logic [WCNT_W-1:0] n_ff, n_in;
   logic [WCNT_W-1:0] k_ff, k_in;
   logic [ON_W-1:0]   act_on_ff, act_on_in;
   logic [ON_W-1:0]   act_off_ff, act_off_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DELAY_W-1:0]  rsp_delay_ff, rsp_delay_in;
   logic [BRIGHT_W-1:0] rsp_bright_ff, rsp_bright_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_error_ff, rsp_error_in;
   logic [ON_W-1:0]     rsp_aon_ff, rsp_aon_in;
   logic [ON_W-1:0]     rsp_aoff_ff, rsp_aoff_in;

   // divider hookup
   logic               div_start;
   logic [WUS_W-1:0]   div_dvd;
   logic [UPT_W-1:0]   div_dvs;
   div_stat_type       div_stat;
   logic [WUS_W-1:0]   div_quo;

   // word store hookup
   logic              buf_wr;
   logic [BUF_W-1:0]  buf_wdata;
   logic [BUF_W-1:0]  buf_rdata;

   logic              csr_wr;
   logic [WCNT_W-1:0] words;
   logic [ON_W:0]     sum_ms;
   logic [REM_W-1:0]  upt_ext;
   logic [REM_W-1:0]  rem_sel;
   logic [WUS_W-1:0]  take;
   logic              out_free;
   logic              is_last;

   //------------------------------------------------------------------
   // register port: pready tied high, write lands at the access cycle
   //------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      upt_in = upt_ff;
      nw_in  = nw_ff;
      if (csr_wr) begin
         case (csr_reg_type'(csr_paddr[2]))
            REG_UPT:       upt_in = csr_pwdata[UPT_W-1:0];
            REG_NUM_WORDS: nw_in  = csr_pwdata[NW_W-1:0];
            default:       upt_in = upt_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(csr_paddr[2]))
         REG_UPT:       csr_prdata = {{(CSR_DW-UPT_W){1'b0}}, upt_ff};
         REG_NUM_WORDS: csr_prdata = {{(CSR_DW-NW_W){1'b0}}, nw_ff};
         default:       csr_prdata = '0;
      endcase
   end

   //------------------------------------------------------------------
   // shared datapath terms
   //------------------------------------------------------------------
   // word count clamps at the store capacity
   assign words = (int'(nw_ff) > MAX_WORDS) ? WCNT_W'(MAX_WORDS) : WCNT_W'(nw_ff);

   assign sum_ms  = {1'b0, on_ms_ff} + {1'b0, off_ms_ff};
   assign upt_ext = {{(REM_W-UPT_W){1'b0}}, upt_ff};
   assign rem_sel = sel_on_ff ? on_rem_ff : off_rem_ff;
   // one word takes at most 127 ticks worth of the remaining time
   assign take    = (rem_sel < {{(REM_W-WUS_W){1'b0}}, word_us_ff}) ?
                    rem_sel[WUS_W-1:0] : word_us_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_last  = (WCNT_W'(k_ff + 1'b1) == n_ff);

   assign req_ready = (state_ff == ST_IDLE);

   //------------------------------------------------------------------
   // sequencer
   //------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      on_ms_in   = on_ms_ff;
      off_ms_in  = off_ms_ff;
      word_us_in = word_us_ff;
      tot_in     = tot_ff;
      cnt_in     = cnt_ff;
      on_rem_in  = on_rem_ff;
      off_rem_in = off_rem_ff;
      sel_on_in  = sel_on_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      act_on_in  = act_on_ff;
      act_off_in = act_off_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_delay_in  = rsp_delay_ff;
      rsp_bright_in = rsp_bright_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_error_in  = rsp_error_ff;
      rsp_aon_in    = rsp_aon_ff;
      rsp_aoff_in   = rsp_aoff_ff;

      div_start = 1'b0;
      div_dvd   = take;
      div_dvs   = upt_ff;

      buf_wr    = 1'b0;
      buf_wdata = {sel_on_ff, div_quo[DELAY_W-1:0]};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               on_ms_in   = req_on_ms;
               off_ms_in  = req_off_ms;
               word_us_in = {upt_ff, 7'b0} - {7'b0, upt_ff};
               tot_in     = '0;
               cnt_in     = '0;
               state_in   = ST_TOTAL;
            end
         end
         // total limit = word limit * usable words, by repeated add
         ST_TOTAL: begin
            if (cnt_ff == words) begin
               state_in = ST_LIMIT;
            end else begin
               tot_in = tot_ff + {{(TOT_W-WUS_W){1'b0}}, word_us_ff};
               cnt_in = cnt_ff + 1'b1;
            end
         end
         // ms compared against a us limit, kept as the original does it
         ST_LIMIT: begin
            if ((upt_ff == '0) ||
                ({{(TOT_W-ON_W){1'b0}}, on_ms_ff} > tot_ff) ||
                ({{(TOT_W-ON_W){1'b0}}, off_ms_ff} > tot_ff) ||
                ({{(TOT_W-ON_W-1){1'b0}}, sum_ms} > tot_ff)) begin
               state_in = ST_ERR;
            end else begin
               if ((on_ms_ff == '0) && (off_ms_ff == '0)) begin
                  on_ms_in  = DEFAULT_MS;
                  off_ms_in = DEFAULT_MS;
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            on_rem_in  = mul1000(on_ms_ff);
            off_rem_in = mul1000(off_ms_ff);
            n_in       = '0;
            state_in   = ST_SEL;
         end
         // on portion first, then off portion
         ST_SEL: begin
            if (n_ff == words) begin
               state_in = ST_CHECK;
            end else if (on_rem_ff > upt_ext) begin
               sel_on_in = 1'b1;
               state_in  = ST_TAKE;
            end else if (off_rem_ff > upt_ext) begin
               sel_on_in = 1'b0;
               state_in  = ST_TAKE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_TAKE: begin
            if (sel_on_ff) begin
               on_rem_in = on_rem_ff - {{(REM_W-WUS_W){1'b0}}, take};
            end else begin
               off_rem_in = off_rem_ff - {{(REM_W-WUS_W){1'b0}}, take};
            end
            div_start = 1'b1;
            state_in  = ST_WDIV;
         end
         ST_WDIV: begin
            if (div_stat.done) begin
               buf_wr   = 1'b1;
               n_in     = n_ff + 1'b1;
               state_in = ST_SEL;
            end
         end
         // reject when nothing formed or more than a tick left over
         ST_CHECK: begin
            if ((n_ff == '0) || (on_rem_ff > upt_ext) || (off_rem_ff > upt_ext)) begin
               state_in = ST_ERR;
            end else begin
               div_start = 1'b1;
               div_dvd   = on_rem_ff[WUS_W-1:0];
               div_dvs   = US_PER_MS;
               state_in  = ST_FON;
            end
         end
         ST_FON: begin
            if (div_stat.done) begin
               act_on_in = on_ms_ff - div_quo[ON_W-1:0];
               state_in  = ST_FOFFST;
            end
         end
         ST_FOFFST: begin
            div_start = 1'b1;
            div_dvd   = off_rem_ff[WUS_W-1:0];
            div_dvs   = US_PER_MS;
            state_in  = ST_FOFF;
         end
         ST_FOFF: begin
            if (div_stat.done) begin
               act_off_in = off_ms_ff - div_quo[ON_W-1:0];
               k_in       = '0;
               state_in   = ST_ERD;
            end
         end
         ST_ERD: begin
            state_in = ST_EWR;
         end
         // final word carries the return marker and the realized times
         ST_EWR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_delay_in  = buf_rdata[DELAY_W-1:0];
               rsp_bright_in = {is_last, buf_rdata[DELAY_W] ? BRIGHT_ON : BRIGHT_OFF};
               rsp_last_in   = is_last;
               rsp_error_in  = 1'b0;
               rsp_aon_in    = is_last ? act_on_ff : '0;
               rsp_aoff_in   = is_last ? act_off_ff : '0;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_ERD;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_delay_in  = '0;
               rsp_bright_in = '0;
               rsp_last_in   = 1'b1;
               rsp_error_in  = 1'b1;
               rsp_aon_in    = '0;
               rsp_aoff_in   = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         upt_ff       <= UPT_RESET;
         nw_ff        <= NW_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         upt_ff       <= upt_in;
         nw_ff        <= nw_in;
      end
      on_ms_ff      <= on_ms_in;
      off_ms_ff     <= off_ms_in;
      word_us_ff    <= word_us_in;
      tot_ff        <= tot_in;
      cnt_ff        <= cnt_in;
      on_rem_ff     <= on_rem_in;
      off_rem_ff    <= off_rem_in;
      sel_on_ff     <= sel_on_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      act_on_ff     <= act_on_in;
      act_off_ff    <= act_off_in;
      rsp_delay_ff  <= rsp_delay_in;
      rsp_bright_ff <= rsp_bright_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_error_ff  <= rsp_error_in;
      rsp_aon_ff    <= rsp_aon_in;
      rsp_aoff_ff   <= rsp_aoff_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tick_delay      = rsp_delay_ff;
   assign rsp_word_brightness = rsp_bright_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_error           = rsp_error_ff;
   assign rsp_actual_on_ms    = rsp_aon_ff;
   assign rsp_actual_off_ms   = rsp_aoff_ff;

   //------------------------------------------------------------------
   // shared bit-serial divider: tick counts and the ms conversion
   //------------------------------------------------------------------
   lbpc_div #(
      .DVD_W (WUS_W),
      .DVS_W (UPT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   //------------------------------------------------------------------
   // word store: tick delay plus on/off flag per control word
   //------------------------------------------------------------------
   lbpc_ram #(
      .WIDTH (BUF_W),
      .DEPTH (MAX_WORDS)
   ) u_wbuf (
      .clock   (clock),
      .wr_en   (buf_wr),
      .wr_addr (n_ff[ADDR_W-1:0]),
      .wr_data (buf_wdata),
      .rd_addr (k_ff[ADDR_W-1:0]),
      .rd_data (buf_rdata)
   );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the LED blink pattern compiler core.
module tb_top
   import lbpc_pkg::*;
();

   // Tick count that fills one control word, and the word store size.
   localparam longint unsigned TICKS_PER_WORD = 127;
   localparam int              TB_MAX_WORDS   = MAX_WORDS_DEF;
   // Quiet cycles allowed with no word moving on any port. The limit must cover
   // the compute of the slowest word, plus receiver stalls and sender gaps.
   localparam int              QUIET_LIMIT    = 5000;
   // Cycles to wait after the last expected word for stray output.
   localparam int              TAIL_CYCLES    = 400;
   localparam int              REPORT_LIMIT   = 40;

   // One result word as the block presents it.
   typedef struct packed {
      logic [DELAY_W-1:0]  tick_delay;
      logic [BRIGHT_W-1:0] brightness;
      logic                last;
      logic                error;
      logic [ON_W-1:0]     actual_on_ms;
      logic [ON_W-1:0]     actual_off_ms;
   } blink_word_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   logic [ON_W-1:0]     req_on_ms   = '0;
   logic [ON_W-1:0]     req_off_ms  = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [DELAY_W-1:0]  rsp_tick_delay;
   logic [BRIGHT_W-1:0] rsp_word_brightness;
   logic                rsp_last;
   logic                rsp_error;
   logic [ON_W-1:0]     rsp_actual_on_ms;
   logic [ON_W-1:0]     rsp_actual_off_ms;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // Shadow copy of the two registers, kept in step with every CSR write.
   logic [UPT_W-1:0]    shadow_upt       = UPT_RESET;
   logic [NW_W-1:0]     shadow_num_words = NW_RESET;

   // Words still owed by the block, oldest first.
   blink_word_type      pending_words[$];
   int                  fail_count   = 0;
   int                  burst_left   = 0;
   int                  quiet_cycles = 0;
   int                  stall_timer  = 0;
   int                  stall_mode   = 0;

   led_blink_pattern_compiler_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_on_ms           (req_on_ms),
      .req_off_ms          (req_off_ms),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_tick_delay      (rsp_tick_delay),
      .rsp_word_brightness (rsp_word_brightness),
      .rsp_last            (rsp_last),
      .rsp_error           (rsp_error),
      .rsp_actual_on_ms    (rsp_actual_on_ms),
      .rsp_actual_off_ms   (rsp_actual_off_ms),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Pattern predictor: compiles one on/off request into the words the
   // block must return, using the shadow registers.
   // ------------------------------------------------------------------
   task automatic compile_blink_words(input logic [ON_W-1:0] on_req,
                                      input logic [ON_W-1:0] off_req);
      blink_word_type     w;
      longint unsigned    on_ms, off_ms, upt, word_us, total_us;
      longint unsigned    on_left, off_left, take;
      int                 n_avail, n_formed, k;
      logic               rejected, done;
      logic [DELAY_W-1:0] delays [TB_MAX_WORDS];
      logic               lit    [TB_MAX_WORDS];
      on_ms    = on_req;
      off_ms   = off_req;
      upt      = shadow_upt;
      n_avail  = (shadow_num_words > TB_MAX_WORDS) ? TB_MAX_WORDS : shadow_num_words;
      n_formed = 0;
      on_left  = 0;
      off_left = 0;
      rejected = (upt == 0);
      if (!rejected) begin
         // limit check compares milliseconds against a microsecond limit
         word_us  = upt * TICKS_PER_WORD;
         total_us = word_us * n_avail;
         rejected = on_ms > total_us || off_ms > total_us || on_ms + off_ms > total_us;
      end
      if (!rejected) begin
         if (on_ms == 0 && off_ms == 0) begin
            on_ms  = DEFAULT_MS;
            off_ms = DEFAULT_MS;
         end
         on_left  = on_ms * US_PER_MS;
         off_left = off_ms * US_PER_MS;
         done     = 1'b0;
         // on portion first, then off; a remainder of one tick or less is dropped
         while (!done && n_formed < n_avail) begin
            if (on_left > upt) begin
               take            = (on_left < word_us) ? on_left : word_us;
               on_left         = on_left - take;
               lit[n_formed]   = 1'b1;
            end else if (off_left > upt) begin
               take            = (off_left < word_us) ? off_left : word_us;
               off_left        = off_left - take;
               lit[n_formed]   = 1'b0;
            end else begin
               done = 1'b1;
            end
            if (!done) begin
               delays[n_formed] = DELAY_W'(take / upt);
               n_formed++;
            end
         end
         rejected = (n_formed == 0) || on_left > upt || off_left > upt;
      end
      if (rejected) begin
         w       = '0;
         w.last  = 1'b1;
         w.error = 1'b1;
         pending_words.push_back(w);
      end else begin
         for (k = 0; k < n_formed; k++) begin
            w            = '0;
            w.tick_delay = delays[k];
            w.last       = (k == n_formed - 1);
            // bit 7 marks the return on the final word
            w.brightness = {w.last, lit[k] ? BRIGHT_ON : BRIGHT_OFF};
            if (w.last) begin
               w.actual_on_ms  = ON_W'(on_ms - on_left / US_PER_MS);
               w.actual_off_ms = ON_W'(off_ms - off_left / US_PER_MS);
            end
            pending_words.push_back(w);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Request sender: bursts of random length, random gaps in between.
   // valid stays high across a burst; the predictor runs on acceptance.
   // ------------------------------------------------------------------
   task automatic send_blink_request(input logic [ON_W-1:0] on_ms,
                                     input logic [ON_W-1:0] off_ms);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 40);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 6);
      end
      req_valid  <= 1'b1;
      req_on_ms  <= on_ms;
      req_off_ms <= off_ms;
      do @(posedge clock); while (!req_ready);
      compile_blink_words(on_ms, off_ms);
      burst_left--;
      if (burst_left == 0)
         req_valid <= 1'b0;
   endtask

   // Stop sending and hold until every owed word has been returned.
   task automatic settle_blink_queue();
      if (burst_left != 0) begin
         req_valid  <= 1'b0;
         burst_left = 0;
      end
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_csr(input csr_reg_type which, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(4 * int'(which));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (which == REG_UPT)
         shadow_upt = value[UPT_W-1:0];
      else
         shadow_num_words = value[NW_W-1:0];
   endtask

   task automatic set_tick_and_words(input logic [UPT_W-1:0] upt,
                                     input logic [NW_W-1:0] num_words);
      settle_blink_queue();
      write_csr(REG_UPT, CSR_DW'(upt));
      write_csr(REG_NUM_WORDS, CSR_DW'(num_words));
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // ------------------------------------------------------------------
   // Result checker: every accepted word against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : word_checker
      blink_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display({"%0t: unexpected word: expected none, ",
                         "got delay %0d bright %h last %b error %b"},
                        $time, rsp_tick_delay, rsp_word_brightness, rsp_last, rsp_error);
         end else begin
            want = pending_words.pop_front();
            check_field("tick_delay", want.tick_delay, rsp_tick_delay);
            check_field("word_brightness", want.brightness, rsp_word_brightness);
            check_field("last", want.last, rsp_last);
            check_field("error", want.error, rsp_error);
            check_field("actual_on_ms", want.actual_on_ms, rsp_actual_on_ms);
            check_field("actual_off_ms", want.actual_off_ms, rsp_actual_off_ms);
         end
      end
   end

   // Receiver stall pattern: modes of random length - always ready,
   // coin-flip ready, or mostly stalled.
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= $urandom_range(0, 2);
         stall_timer <= $urandom_range(20, 300);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= $urandom_range(0, 1);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 7) == 0);
         end
      endcase
   end

   // Watchdog: ends the run if no word moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog expired with %0d words owed", $time, pending_words.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // Reset settings: 10 ms ticks, eight words.
   task automatic test_default_pattern();
      send_blink_request(0, 0);                  // both zero: 500/500 default
      send_blink_request(1000, 1000);
      send_blink_request(10160, 0);              // exactly eight full words
      send_blink_request(5080, 5080);            // four words each
      send_blink_request(15, 0);                 // one short word
      send_blink_request(1, 0);                  // under one tick: no word
      send_blink_request(10160, 20);             // off time left over
      send_blink_request(22'h3FFFFF, 22'h3FFFFF);
      send_blink_request(22'h2AAAAA, 22'h155555);
      send_blink_request(0, 22'h3FFFFF);
   endtask

   // Smallest tick length and a single word: the ms-vs-us limit bites.
   task automatic test_limit_check();
      set_tick_and_words(3921, 1);
      send_blink_request(497968, 0);             // on above limit
      send_blink_request(0, 497968);             // off above limit
      send_blink_request(300000, 300000);        // only the sum above limit
      send_blink_request(497, 0);
      send_blink_request(498, 0);                // sub-tick remainder dropped
   endtask

   // Empty word store: nothing can ever be formed.
   task automatic test_zero_word_store();
      set_tick_and_words(10000, 0);
      send_blink_request(0, 0);
      send_blink_request(1, 0);
   endtask

   // Word counts above the store size act as a full store.
   task automatic test_word_count_clamp();
      set_tick_and_words(20'hFFFFF, 15);
      send_blink_request(1065352, 0);
      send_blink_request(2000, 3000);
      send_blink_request(0, 0);                  // default is under one tick
      set_tick_and_words(20'hFFFFF, 9);
      send_blink_request(532676, 532676);
   endtask

   // Zero tick length rejects everything.
   task automatic test_zero_tick_length();
      set_tick_and_words(0, 8);
      send_blink_request(0, 0);
      send_blink_request(100, 100);
   endtask

   // ------------------------------------------------------------------
   // Random traffic under one register setting. Most requests fit the
   // word store (random word split, random content), some hug the tick
   // boundary, the rest are raw 22-bit noise.
   // ------------------------------------------------------------------
   function automatic logic [ON_W-1:0] span_ms(input int unsigned n_words,
                                               input longint unsigned word_ms);
      if (n_words == 0)
         return '0;
      return ON_W'($urandom_range(32'((n_words - 1) * word_ms), 32'(n_words * word_ms)));
   endfunction

   task automatic test_random_blinks(input logic [UPT_W-1:0] upt,
                                     input logic [NW_W-1:0] num_words, input int count);
      longint unsigned word_ms, near_ms;
      int unsigned     n_avail, n_on, n_off, kind;
      logic [ON_W-1:0] on_ms, off_ms;
      set_tick_and_words(upt, num_words);
      n_avail = (num_words > TB_MAX_WORDS) ? TB_MAX_WORDS : num_words;
      word_ms = (longint'(upt) * TICKS_PER_WORD) / US_PER_MS;
      near_ms = 2 * (longint'(upt) / US_PER_MS) + 2;
      repeat (count) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            n_on   = $urandom_range(0, n_avail);
            n_off  = $urandom_range(0, n_avail - n_on);
            on_ms  = span_ms(n_on, word_ms);
            off_ms = span_ms(n_off, word_ms);
         end else if (kind < 8) begin
            on_ms  = ON_W'($urandom_range(0, 32'(near_ms)));
            off_ms = ON_W'($urandom_range(0, 32'(near_ms)));
         end else begin
            on_ms  = ON_W'($urandom());
            off_ms = ON_W'($urandom());
         end
         send_blink_request(on_ms, off_ms);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_pattern();
      test_limit_check();
      test_zero_word_store();
      test_word_count_clamp();
      test_zero_tick_length();

      // each phase drains fully before its register writes
      test_random_blinks(UPT_RESET, NW_RESET, 45);
      test_random_blinks(3921, 3, 40);
      test_random_blinks(1000000, 8, 35);
      test_random_blinks($urandom_range(3921, 1000000), $urandom_range(0, 15), 35);
      test_random_blinks($urandom_range(3921, 1000000), $urandom_range(1, 8), 35);
      test_random_blinks($urandom_range(0, 20'hFFFFF), $urandom_range(0, 15), 40);

      settle_blink_queue();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/lbpc_pkg.sv
sv/lbpc_ram.sv
sv/lbpc_div.sv
sv/led_blink_pattern_compiler_core.sv
bench/tb_top.sv
